@@ hdl/trapezoid_motion_profile_top_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef TRAPEZOID_MOTION_PROFILE_TOP_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_TOP_MACROS_SVH

// Clocked on i_clk, quiet while reset is asserted.
`define TRAPMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked on i_clk, also checked across reset.
`define TRAPMP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/trapmp_pkg.sv @@
`default_nettype none

package trapmp_pkg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

endpackage

`default_nettype wire

@@ hdl/trapmp_alu.sv @@
`default_nettype none

// Shared bit-serial unit: shift-add multiply, restoring divide, digit-by-digit
// square root. One result bit (or one multiplier bit) per cycle.
module trapmp_alu
    import trapmp_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int EXT_BITS  = 66
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_alu_ctl             i_ctl,
    input  logic [EXT_BITS-1:0]  i_opa,
    input  logic [WORD_BITS:0]   i_opb,
    output logic [EXT_BITS-1:0]  o_res,
    output logic                 o_done
);

    localparam int W  = WORD_BITS;
    localparam int XW = EXT_BITS;
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 4;
    localparam int CW = $clog2(XW + 1);

    logic          r_busy;
    logic          r_done;
    t_alu_op       r_op;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_x;
    logic [W:0]    r_y;
    logic [XW-1:0] r_q;
    logic [RW-1:0] r_r;

    logic [XW-1:0] w_madd;
    logic [RW-1:0] w_dsh;
    logic          w_dge;
    logic [RW-1:0] w_ssh;
    logic [RW-1:0] w_trial;
    logic          w_sge;

    always_comb begin
        w_madd  = r_q + r_x;
        // divide: bring down the next numerator bit
        w_dsh   = {r_r[RW-2:0], r_x[XW-1]};
        w_dge   = w_dsh >= RW'(r_y);
        // root: bring down the next pair of radicand bits
        w_ssh   = {r_r[RW-3:0], r_x[SW-1:SW-2]};
        w_trial = RW'({r_q[W:0], 2'b01});
        w_sge   = w_ssh >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_q    <= '0;
                r_r    <= '0;
                r_x    <= i_opa;
                r_y    <= i_opb;
                case (i_ctl.op)
                    OP_MUL:  r_cnt <= CW'(W);
                    OP_DIV:  r_cnt <= CW'(XW);
                    OP_SQRT: r_cnt <= CW'(W + 1);
                    default: r_cnt <= CW'(W);
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_MUL: begin
                        if (r_y[0]) begin
                            r_q <= w_madd;
                        end
                        r_x <= r_x << 1;
                        r_y <= r_y >> 1;
                    end
                    OP_DIV: begin
                        r_r <= w_dge ? (w_dsh - RW'(r_y)) : w_dsh;
                        r_q <= {r_q[XW-2:0], w_dge};
                        r_x <= r_x << 1;
                    end
                    OP_SQRT: begin
                        r_r <= w_sge ? (w_ssh - w_trial) : w_ssh;
                        r_q <= {r_q[XW-2:0], w_sge};
                        r_x <= r_x << 2;
                    end
                    default: ;
                endcase
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res  = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

@@ hdl/trapezoid_motion_profile_top.sv @@
`default_nettype none

// Trapezoidal motion planner, fixed point with FRAC_BITS fraction bits (distance,
// position and velocity signed, the rest unsigned). tuser = 0 plans a segment
// (start velocity is the previous plan's reached final velocity), tuser = 1
// samples position and velocity at sample_time; every item gives one result.
// Every multiply, division and square root runs through one bit-serial unit.
// A full plan uses up to four multiplies, two roots and five divisions; a
// constant-speed plan one division. A sample takes one multiply or, on a
// ramp, three. The input is not ready while an item is in work; a finished
// result waits in the output register.
module trapezoid_motion_profile_top
    import trapmp_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // distance, final_velocity, vel_limit, accel, sample_time
    input  logic [((5*WORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // req_type
    input  logic [0:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // position, velocity, total_time, reached_final_velocity
    output logic [((4*WORD_BITS+7)/8)*8-1:0]      o_m_axis_tdata
);

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int W1    = W + 1;
    localparam int W2    = W + 2;
    localparam int DW    = 2 * W;
    localparam int XW    = (2 * W + 2 > W + F + 1) ? 2 * W + 2 : W + F + 1;
    localparam int PW    = XW + 1;
    localparam int MW    = PW - F;
    localparam int OUT_W = ((4 * W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_CDIV, ST_SQI, ST_AD, ST_CLMP, ST_SQF, ST_VC,
        ST_SQC, ST_DR, ST_DF, ST_TR, ST_TF, ST_CRU, ST_TC, ST_TOT,
        ST_SEL, ST_M1, ST_M2, ST_M3, ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        SC_EXT, SC_CONST, SC_RISE, SC_CRUISE, SC_FALL
    } t_scase;

    t_state        r_state;
    logic          r_iss;
    logic          r_isplan;
    logic          r_bwd;
    logic [W-1:0]  r_dist_total, r_vel_start, r_vel_cruise, r_vel_end, r_accel_held;
    logic [W-1:0]  r_dist_rise, r_dist_cruise, r_time_rise, r_time_cruise, r_time_total;
    logic [W-1:0]  r_vlim, r_vf, r_fall_d, r_fall_t;
    logic [DW-1:0] r_sqi, r_sqf, r_sqc, r_ad;
    logic [W-1:0]  r_t, r_tx, r_mop, r_mop2, r_inc;
    t_scase        r_case;
    logic [DW-1:0] r_p1, r_p2, r_p3;
    logic          r_ovalid;
    logic [W-1:0]  r_pos, r_vel, r_tt, r_rfv;

    t_alu_ctl      w_ctl;
    logic          w_need;
    logic [XW-1:0] w_opa, w_res;
    logic [W:0]    w_opb;
    logic          w_done;

    logic [W-1:0]  w_in_dist, w_in_fv, w_in_vlim, w_in_acc, w_in_t, w_in_dabs;
    logic [W-1:0]  w_rsat, w_isat;
    logic [W:0]    w_root;
    logic [XW-1:0] w_sqi_x, w_two_ad, w_clmp_arg, w_vc_arg;
    logic [DW-1:0] w_rise_num, w_fall_num;
    logic [W:0]    w_two_a, w_used, w_trtc;
    logic [W1-1:0] w_dr_dc;
    logic [W2-1:0] w_tot;
    logic [PW-1:0] w_pos, w_fa, w_fb;
    logic [W:0]    w_vmag;
    logic [MW-1:0] w_pmag;
    logic [W-1:0]  w_lim, w_pclip, w_vclip, w_pos_s, w_vel_s;

    trapmp_alu #(
        .WORD_BITS (W),
        .EXT_BITS  (XW)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_res   (w_res),
        .o_done  (w_done)
    );

    always_comb begin
        w_in_dist  = i_s_axis_tdata[W-1:0];
        w_in_fv    = i_s_axis_tdata[2*W-1:W];
        w_in_vlim  = i_s_axis_tdata[3*W-1:2*W];
        w_in_acc   = i_s_axis_tdata[4*W-1:3*W];
        w_in_t     = i_s_axis_tdata[5*W-1:4*W];
        w_in_dabs  = w_in_dist[W-1] ? (-w_in_dist) : w_in_dist;

        w_rsat     = (|w_res[XW-1:W]) ? '1 : w_res[W-1:0];
        w_isat     = (|w_res[XW-1:W+F]) ? '1 : w_res[W+F-1:F];
        w_root     = w_res[W:0];

        w_sqi_x    = XW'(r_sqi);
        w_two_ad   = XW'(r_ad) << 1;
        if (r_vf < r_vel_start) begin
            w_clmp_arg = (w_sqi_x < w_two_ad) ? '0 : (w_sqi_x - w_two_ad);
        end else begin
            w_clmp_arg = w_sqi_x + w_two_ad;
        end
        w_vc_arg   = ((w_sqi_x + XW'(r_sqf)) >> 1) + XW'(r_ad);
        w_rise_num = (r_sqc < r_sqi) ? '0 : (r_sqc - r_sqi);
        w_fall_num = (r_sqc < r_sqf) ? '0 : (r_sqc - r_sqf);
        w_two_a    = {r_accel_held, 1'b0};
        w_used     = W1'(r_dist_rise) + W1'(r_fall_d);
        w_trtc     = W1'(r_time_rise) + W1'(r_time_cruise);
        w_dr_dc    = W1'(r_dist_rise) + W1'(r_dist_cruise);
        w_tot      = W2'(r_time_rise) + W2'(r_time_cruise) + W2'(r_fall_t);
    end

    // operand selection for the shared unit
    always_comb begin
        w_need = 1'b0;
        w_ctl.op = OP_MUL;
        w_opa  = '0;
        w_opb  = '0;
        case (r_state)
            ST_CDIV: begin
                w_need = 1'b1;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(r_dist_total) << F;
                w_opb  = {1'b0, r_vlim};
            end
            ST_SQI: begin
                w_need = 1'b1;
                w_opa  = XW'(r_vel_start);
                w_opb  = {1'b0, r_vel_start};
            end
            ST_AD: begin
                w_need = 1'b1;
                w_opa  = XW'(r_accel_held);
                w_opb  = {1'b0, r_dist_total};
            end
            ST_CLMP: begin
                w_need = r_vf != r_vel_start;
                w_ctl.op = OP_SQRT;
                w_opa  = w_clmp_arg;
            end
            ST_SQF: begin
                w_need = 1'b1;
                w_opa  = XW'(r_vf);
                w_opb  = {1'b0, r_vf};
            end
            ST_VC: begin
                w_need = 1'b1;
                w_ctl.op = OP_SQRT;
                w_opa  = w_vc_arg;
            end
            ST_SQC: begin
                w_need = 1'b1;
                w_opa  = XW'(r_vel_cruise);
                w_opb  = {1'b0, r_vel_cruise};
            end
            ST_DR: begin
                w_need = 1'b1;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(w_rise_num);
                w_opb  = w_two_a;
            end
            ST_DF: begin
                w_need = 1'b1;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(w_fall_num);
                w_opb  = w_two_a;
            end
            ST_TR: begin
                w_need = r_vel_cruise > r_vel_start;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(r_vel_cruise - r_vel_start) << F;
                w_opb  = {1'b0, r_accel_held};
            end
            ST_TF: begin
                w_need = r_vel_cruise > r_vel_end;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(r_vel_cruise - r_vel_end) << F;
                w_opb  = {1'b0, r_accel_held};
            end
            ST_TC: begin
                w_need = 1'b1;
                w_ctl.op = OP_DIV;
                w_opa  = XW'(r_dist_cruise) << F;
                w_opb  = {1'b0, r_vel_cruise};
            end
            ST_M1: begin
                w_need = 1'b1;
                w_opa  = XW'(r_mop);
                w_opb  = {1'b0, r_tx};
            end
            ST_M2: begin
                w_need = 1'b1;
                w_opa  = XW'(r_mop2);
                w_opb  = {1'b0, r_tx};
            end
            ST_M3: begin
                w_need = 1'b1;
                w_opa  = XW'(r_inc);
                w_opb  = {1'b0, r_tx};
            end
            default: ;
        endcase
        w_ctl.start = w_need && !r_iss;
    end

    // sample result assembly
    always_comb begin
        w_fa = (PW'(w_dr_dc) << F) + PW'(r_p2);
        w_fb = PW'(r_p3 >> 1);
        case (r_case)
            SC_EXT: begin
                w_pos  = (PW'(r_dist_total) << F) + PW'(r_p1);
                w_vmag = W1'(r_vel_end);
            end
            SC_CONST: begin
                w_pos  = PW'(r_p1);
                w_vmag = W1'(r_vel_start);
            end
            SC_RISE: begin
                w_pos  = PW'(r_p2) + PW'(r_p3 >> 1);
                w_vmag = W1'(r_vel_start) + W1'(r_inc);
            end
            SC_CRUISE: begin
                w_pos  = (PW'(r_dist_rise) << F) + PW'(r_p1);
                w_vmag = W1'(r_vel_cruise);
            end
            SC_FALL: begin
                w_pos  = (w_fa < w_fb) ? '0 : (w_fa - w_fb);
                w_vmag = (r_vel_cruise > r_inc) ? W1'(r_vel_cruise - r_inc) : '0;
            end
            default: begin
                w_pos  = '0;
                w_vmag = '0;
            end
        endcase
        w_pmag  = w_pos[PW-1:F];
        // backward moves may reach the most negative value
        w_lim   = r_bwd ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        w_pclip = (w_pmag > MW'(w_lim)) ? w_lim : w_pmag[W-1:0];
        w_vclip = (w_vmag > W1'(w_lim)) ? w_lim : w_vmag[W-1:0];
        w_pos_s = r_bwd ? (-w_pclip) : w_pclip;
        w_vel_s = r_bwd ? (-w_vclip) : w_vclip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_iss         <= 1'b0;
            r_ovalid      <= 1'b0;
            r_bwd         <= 1'b0;
            r_dist_total  <= '0;
            r_vel_start   <= '0;
            r_vel_cruise  <= '0;
            r_vel_end     <= '0;
            r_accel_held  <= '0;
            r_dist_rise   <= '0;
            r_dist_cruise <= '0;
            r_time_rise   <= '0;
            r_time_cruise <= '0;
            r_time_total  <= '0;
        end else begin
            if (w_ctl.start) begin
                r_iss <= 1'b1;
            end else if (w_done) begin
                r_iss <= 1'b0;
            end
            if (r_state == ST_FIN && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_isplan <= !i_s_axis_tuser[0];
                        if (!i_s_axis_tuser[0]) begin
                            r_bwd        <= w_in_dist[W-1];
                            r_dist_total <= w_in_dabs;
                            r_vlim       <= w_in_vlim;
                            r_vf         <= (w_in_fv > w_in_vlim) ? w_in_vlim : w_in_fv;
                            r_accel_held <= w_in_acc;
                            r_vel_start  <= r_vel_end;
                            r_state      <= ST_CHK;
                        end else begin
                            r_t     <= w_in_t;
                            r_state <= ST_SEL;
                        end
                    end
                end
                ST_CHK: begin
                    if (r_vel_start == r_vlim && r_vel_start == r_vf) begin
                        // constant speed: cruise only
                        r_vel_cruise  <= r_vlim;
                        r_dist_rise   <= '0;
                        r_time_rise   <= '0;
                        r_dist_cruise <= r_dist_total;
                        if (r_vlim != '0) begin
                            r_state <= ST_CDIV;
                        end else begin
                            r_time_cruise <= '0;
                            r_time_total  <= '0;
                            r_state       <= ST_FIN;
                        end
                    end else begin
                        r_state <= ST_SQI;
                    end
                end
                ST_CDIV: begin
                    if (w_done) begin
                        r_time_cruise <= w_rsat;
                        r_time_total  <= w_rsat;
                        r_state       <= ST_FIN;
                    end
                end
                ST_SQI: begin
                    if (w_done) begin
                        r_sqi   <= w_res[DW-1:0];
                        r_state <= ST_AD;
                    end
                end
                ST_AD: begin
                    if (w_done) begin
                        r_ad    <= w_res[DW-1:0];
                        r_state <= ST_CLMP;
                    end
                end
                ST_CLMP: begin
                    if (!w_need) begin
                        r_state <= ST_SQF;
                    end else if (w_done) begin
                        if (r_vf < r_vel_start) begin
                            r_vf <= (W1'(r_vf) < w_root) ? w_root[W-1:0] : r_vf;
                        end else begin
                            r_vf <= (W1'(r_vf) > w_root) ? w_root[W-1:0] : r_vf;
                        end
                        r_state <= ST_SQF;
                    end
                end
                ST_SQF: begin
                    if (w_done) begin
                        r_sqf     <= w_res[DW-1:0];
                        r_vel_end <= r_vf;
                        r_state   <= ST_VC;
                    end
                end
                ST_VC: begin
                    if (w_done) begin
                        r_vel_cruise <= (w_root > W1'(r_vlim)) ? r_vlim : w_root[W-1:0];
                        if (r_accel_held != '0) begin
                            r_state <= ST_SQC;
                        end else begin
                            r_dist_rise <= '0;
                            r_time_rise <= '0;
                            r_fall_d    <= '0;
                            r_fall_t    <= '0;
                            r_state     <= ST_CRU;
                        end
                    end
                end
                ST_SQC: begin
                    if (w_done) begin
                        r_sqc   <= w_res[DW-1:0];
                        r_state <= ST_DR;
                    end
                end
                ST_DR: begin
                    if (w_done) begin
                        r_dist_rise <= w_rsat;
                        r_state     <= ST_DF;
                    end
                end
                ST_DF: begin
                    if (w_done) begin
                        r_fall_d <= w_rsat;
                        r_state  <= ST_TR;
                    end
                end
                ST_TR: begin
                    if (!w_need) begin
                        r_time_rise <= '0;
                        r_state     <= ST_TF;
                    end else if (w_done) begin
                        r_time_rise <= w_rsat;
                        r_state     <= ST_TF;
                    end
                end
                ST_TF: begin
                    if (!w_need) begin
                        r_fall_t <= '0;
                        r_state  <= ST_CRU;
                    end else if (w_done) begin
                        r_fall_t <= w_rsat;
                        r_state  <= ST_CRU;
                    end
                end
                ST_CRU: begin
                    r_dist_cruise <= (W1'(r_dist_total) > w_used) ?
                                     (r_dist_total - w_used[W-1:0]) : '0;
                    if (r_vel_cruise != '0) begin
                        r_state <= ST_TC;
                    end else begin
                        r_time_cruise <= '0;
                        r_state       <= ST_TOT;
                    end
                end
                ST_TC: begin
                    if (w_done) begin
                        r_time_cruise <= w_rsat;
                        r_state       <= ST_TOT;
                    end
                end
                ST_TOT: begin
                    r_time_total <= (|w_tot[W2-1:W]) ? '1 : w_tot[W-1:0];
                    r_state      <= ST_FIN;
                end
                ST_SEL: begin
                    if (r_t > r_time_total) begin
                        r_case <= SC_EXT;
                        r_tx   <= r_t - r_time_total;
                        r_mop  <= r_vel_end;
                    end else if (r_vel_start == r_vel_cruise && r_vel_start == r_vel_end) begin
                        r_case <= SC_CONST;
                        r_tx   <= r_t;
                        r_mop  <= r_vel_start;
                    end else if (r_t < r_time_rise) begin
                        r_case <= SC_RISE;
                        r_tx   <= r_t;
                        r_mop  <= r_accel_held;
                        r_mop2 <= r_vel_start;
                    end else if (W1'(r_t) < w_trtc) begin
                        r_case <= SC_CRUISE;
                        r_tx   <= r_t - r_time_rise;
                        r_mop  <= r_vel_cruise;
                    end else begin
                        r_case <= SC_FALL;
                        r_tx   <= r_t - r_time_rise - r_time_cruise;
                        r_mop  <= r_accel_held;
                        r_mop2 <= r_vel_cruise;
                    end
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    if (w_done) begin
                        r_p1 <= w_res[DW-1:0];
                        if (r_case == SC_RISE || r_case == SC_FALL) begin
                            r_inc   <= w_isat;
                            r_state <= ST_M2;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_M2: begin
                    if (w_done) begin
                        r_p2    <= w_res[DW-1:0];
                        r_state <= ST_M3;
                    end
                end
                ST_M3: begin
                    if (w_done) begin
                        r_p3    <= w_res[DW-1:0];
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_pos    <= r_isplan ? '0 : w_pos_s;
                        r_vel    <= r_isplan ? '0 : w_vel_s;
                        r_tt     <= r_time_total;
                        r_rfv    <= r_vel_end;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_W'({r_rfv, r_tt, r_vel, r_pos});

endmodule

`default_nettype wire

@@ hdl/trapmp_chk.sv @@
`default_nettype none

`include "trapezoid_motion_profile_top_macros.svh"

module trapmp_chk #(
    parameter int WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             o_s_axis_tready,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [((4*WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    // a stalled result transaction holds
    `TRAPMP_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // out of reset: idle, nothing pending
    `TRAPMP_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "not idle after reset")

    // an accepted item keeps the block busy
    `TRAPMP_ASSERT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "ready right after accepting an item")

    // a new result only appears at the end of work
    `TRAPMP_ASSERT(a_result_after_work, $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready), "result raised while idle")

endmodule

bind trapezoid_motion_profile_top trapmp_chk #(.WORD_BITS(WORD_BITS)) u_trapmp_chk (.*);

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import trapmp_pkg::*;

    localparam bit REQ_PLAN = 1'b0;
    localparam bit REQ_SAMPLE = 1'b1;
    localparam int N_ITEMS = 1050;

    typedef struct {
        bit        req;
        bit [31:0] seg_dist;
        bit [31:0] vfin;
        bit [31:0] vmax;
        bit [31:0] acc;
        bit [31:0] t;
    } t_item;

    typedef struct {
        bit [31:0] pos;
        bit [31:0] vel;
        bit [31:0] tot;
        bit [31:0] vend;
    } t_motion;

    typedef struct {
        t_item   it;
        bit      typed;
        t_motion res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // distance, final_velocity, vel_limit, accel, sample_time
    logic [159:0] i_s_axis_tdata;
    // req_type
    logic [0:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // position, velocity, total_time, reached_final_velocity
    logic [127:0] o_m_axis_tdata;

    trapezoid_motion_profile_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // profile state mirrored by the predictor
    bit        pf_back;
    bit [31:0] pf_dist, pf_vstart, pf_vcruise, pf_vend, pf_acc;
    bit [31:0] pf_drise, pf_dcruise, pf_trise, pf_tcruise, pf_ttotal;

    t_motion motion_q[$];
    int      n_err, n_plans, n_samples, n_results;
    bit      no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", motion_q.size());
        $display("status: fail");
        $finish;
    end

    function automatic bit [127:0] isqrt(bit [127:0] x);
        bit [63:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (!(x < {64'd0, c} * {64'd0, c})) r = c;
        end
        return {64'd0, r};
    endfunction

    function automatic bit [31:0] sat_w(bit [127:0] x);
        return (x > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic bit [127:0] sub_floor(bit [127:0] a, bit [127:0] b);
        return (a < b) ? '0 : a - b;
    endfunction

    function automatic bit [31:0] to_sword(bit [127:0] mag, bit neg);
        bit [127:0] lim, m;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        m = (mag > lim) ? lim : mag;
        return neg ? -m[31:0] : m[31:0];
    endfunction

    function automatic void plan_segment(t_item it);
        bit [127:0] raw, d, vf, vlim, a, vi, m, vc, sq_i, sq_f, sq_c, two_ad, two_a;
        bit [127:0] fall_d, fall_t, used, dc, tot;
        raw = it.seg_dist;
        pf_back = it.seg_dist[31];
        d = pf_back ? {96'd0, -it.seg_dist} : raw;
        vlim = it.vmax;
        vf = (it.vfin > it.vmax) ? it.vmax : it.vfin;
        a = it.acc;
        vi = pf_vend;
        pf_dist = d[31:0];
        pf_vstart = pf_vend;
        pf_acc = it.acc;
        fall_d = '0;
        fall_t = '0;
        if (vi == vlim && vi == vf) begin
            pf_vcruise = vlim[31:0];
            pf_drise = '0;
            pf_trise = '0;
            pf_dcruise = d[31:0];
            pf_tcruise = (vlim != 0) ? sat_w((d << 16) / vlim) : '0;
            pf_ttotal = pf_tcruise;
            return;
        end
        sq_i = vi * vi;
        two_ad = (a * d) << 1;
        if (vf < vi) begin
            m = isqrt(sub_floor(sq_i, two_ad));
            if (vf < m) vf = m;
        end else if (vf > vi) begin
            m = isqrt(sq_i + two_ad);
            if (vf > m) vf = m;
        end
        pf_vend = vf[31:0];
        sq_f = vf * vf;
        vc = isqrt(((sq_i + sq_f) >> 1) + a * d);
        if (vc > vlim) vc = vlim;
        pf_vcruise = vc[31:0];
        if (a != 0) begin
            sq_c = vc * vc;
            two_a = a << 1;
            pf_drise = sat_w(sub_floor(sq_c, sq_i) / two_a);
            fall_d = sat_w(sub_floor(sq_c, sq_f) / two_a);
            pf_trise = (vc > vi) ? sat_w(((vc - vi) << 16) / a) : '0;
            fall_t = (vc > vf) ? sat_w(((vc - vf) << 16) / a) : '0;
        end else begin
            pf_drise = '0;
            pf_trise = '0;
        end
        used = pf_drise + fall_d;
        dc = (d > used) ? d - used : '0;
        pf_dcruise = dc[31:0];
        pf_tcruise = (vc != 0) ? sat_w((dc << 16) / vc) : '0;
        tot = pf_trise + pf_tcruise + fall_t;
        pf_ttotal = sat_w(tot);
    endfunction

    function automatic t_motion profile_step(t_item it);
        t_motion r;
        bit [127:0] t, pos, v, inc, tp, dec, tr, tc;
        r = '{default: '0};
        if (it.req == REQ_PLAN) begin
            plan_segment(it);
        end else begin
            t = it.t;
            tr = pf_trise;
            tc = pf_tcruise;
            if (t > pf_ttotal) begin
                v = pf_vend;
                pos = ({96'd0, pf_dist} << 16) + v * (t - pf_ttotal);
            end else if (pf_vstart == pf_vcruise && pf_vstart == pf_vend) begin
                v = pf_vstart;
                pos = v * t;
            end else if (t < tr) begin
                inc = sat_w((pf_acc * t) >> 16);
                v = pf_vstart + inc;
                pos = pf_vstart * t + ((inc * t) >> 1);
            end else if (t < tr + tc) begin
                v = pf_vcruise;
                pos = ({96'd0, pf_drise} << 16) + v * (t - tr);
            end else begin
                tp = t - tr - tc;
                dec = sat_w((pf_acc * tp) >> 16);
                v = (pf_vcruise > dec) ? pf_vcruise - dec : '0;
                pos = sub_floor(((pf_drise + 128'(pf_dcruise)) << 16) + pf_vcruise * tp,
                                (dec * tp) >> 1);
            end
            r.pos = to_sword(pos >> 16, pf_back);
            r.vel = to_sword(v, pf_back);
        end
        r.tot = pf_ttotal;
        r.vend = pf_vend;
        return r;
    endfunction

    task automatic report(string what, bit [31:0] got, bit [31:0] want);
        n_err++;
        $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_motion e;
            if (motion_q.size() == 0) begin
                report("unexpected transaction", o_m_axis_tdata[31:0], 32'd0);
            end else begin
                e = motion_q.pop_front();
                if (o_m_axis_tdata[31:0] != e.pos) report("position", o_m_axis_tdata[31:0], e.pos);
                if (o_m_axis_tdata[63:32] != e.vel) report("velocity", o_m_axis_tdata[63:32], e.vel);
                if (o_m_axis_tdata[95:64] != e.tot) report("total_time", o_m_axis_tdata[95:64], e.tot);
                if (o_m_axis_tdata[127:96] != e.vend)
                    report("final velocity", o_m_axis_tdata[127:96], e.vend);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    task automatic send(t_item it, bit typed, t_motion want);
        t_motion p;
        if (!no_idle && $urandom_range(0, 99) < 20) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {it.t, it.acc, it.vmax, it.vfin, it.seg_dist};
        i_s_axis_tuser <= it.req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        p = profile_step(it);
        motion_q.push_back(typed ? want : p);
        if (it.req == REQ_PLAN) n_plans++;
        else n_samples++;
    endtask

    function automatic bit [31:0] rnd_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000);
        endcase
    endfunction

    function automatic bit [31:0] rnd_time();
        if (pf_ttotal < 32'h4000_0000 && $urandom_range(0, 9) != 0)
            return $urandom_range(0, pf_ttotal + pf_ttotal / 4 + 16);
        return $urandom;
    endfunction

    t_row    dir[$];
    t_item   it;
    t_motion zero_res;
    int      sent;

    function automatic t_row mk_row(bit req, bit [31:0] d, bit [31:0] vf, bit [31:0] vm,
                                    bit [31:0] a, bit [31:0] t, bit typed);
        t_row r;
        r.it = '{req, d, vf, vm, a, t};
        r.typed = typed;
        r.res = '{default: '0};
        return r;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        no_idle = 1'b0;
        zero_res = '{default: '0};
        // after reset everything is zero; a zero plan stays zero
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 0, 1));
        dir.push_back(mk_row(REQ_PLAN, 0, 0, 0, 0, 0, 1));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
        // constant speed with zero limit
        dir.push_back(mk_row(REQ_PLAN, 32'h0007_0000, 0, 0, 32'h0001_0000, 0, 0));
        dir.push_back(mk_row(REQ_PLAN, 32'h000A_0000, 32'h0002_0000, 32'h0004_0000,
                             32'h0001_0000, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0000_8000, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0003_0000, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0005_0000, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        // backward move
        dir.push_back(mk_row(REQ_PLAN, 32'hFFFB_0000, 0, 32'h0003_0000, 32'h0002_0000, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0001_0000, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        // reach 5.0, then hold it: constant speed shortcut
        dir.push_back(mk_row(REQ_PLAN, 32'h0064_0000, 32'h0005_0000, 32'h0005_0000,
                             32'hFFFF_FFFF, 0, 0));
        dir.push_back(mk_row(REQ_PLAN, 32'h0064_0000, 32'h0005_0000, 32'h0005_0000,
                             32'h0001_0000, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0002_0000, 0));
        // start above limit
        dir.push_back(mk_row(REQ_PLAN, 32'h0032_0000, 0, 32'h0002_0000, 32'h0001_0000, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0001_0000, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0020_0000, 0));
        // zero acceleration
        dir.push_back(mk_row(REQ_PLAN, 32'h0010_0000, 32'h0003_0000, 32'h0006_0000, 0, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0001_0000, 0));
        // field extremes
        dir.push_back(mk_row(REQ_PLAN, 32'h8000_0000, '1, '1, '1, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        dir.push_back(mk_row(REQ_PLAN, 32'h7FFF_FFFF, '1, '1, 1, 0, 0));
        dir.push_back(mk_row(REQ_SAMPLE, 0, 0, 0, 0, 32'h0000_0001, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[k]) send(dir[k].it, dir[k].typed, dir[k].typed ? zero_res : dir[k].res);
        sent = dir.size();

        while (sent < N_ITEMS) begin
            no_idle = (sent >= 300 && sent < 450);
            if (sent >= 600 && sent < 610) begin
                i_s_axis_tvalid <= 1'b0;
                while (motion_q.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) begin
                // noise item
                it = '{$urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom, $urandom};
                send(it, 0, zero_res);
                sent++;
            end else begin
                it.req = REQ_PLAN;
                it.seg_dist = rnd_word();
                if ($urandom_range(0, 1)) it.seg_dist = -it.seg_dist;
                it.vmax = rnd_word();
                it.vfin = ($urandom_range(0, 3) == 0) ? it.vmax : rnd_word();
                it.acc = rnd_word();
                it.t = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    it.vmax = pf_vend;
                    it.vfin = pf_vend;
                end
                send(it, 0, zero_res);
                sent++;
                repeat ($urandom_range(2, 6)) begin
                    it.req = REQ_SAMPLE;
                    it.seg_dist = $urandom;
                    it.vfin = $urandom;
                    it.vmax = $urandom;
                    it.acc = $urandom;
                    it.t = rnd_time();
                    send(it, 0, zero_res);
                    sent++;
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("covered %0d plans and %0d samples, %0d results checked",
                 n_plans, n_samples, n_results);
        $display("mismatches: %0d", n_err);
        if (n_err == 0 && motion_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
